### rtl/core/pidsl_pkg.sv
// pidsl_pkg: shared widths, register indexes and operand types for the
// pid controller core with slew and windup limits
// no dependencies
`timescale 1ns / 1ps

package pidsl_pkg;

   // fixed point format of error, gains and drive
   localparam int unsigned FRAC_BITS = 16;

   // field and state widths
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SUM_W   = 48;
   localparam int unsigned LIMIT_W = 47;
   localparam int unsigned STEP_W  = 31;

   // term unit: split multiply of a 47 bit magnitude by a 32 bit magnitude
   localparam int unsigned OP_A_W  = 47;
   localparam int unsigned OP_B_W  = 32;
   localparam int unsigned SPLIT_W = 24;
   localparam int unsigned PROD_W  = OP_A_W + OP_B_W;
   localparam int unsigned TERM_W  = 62;
   localparam int unsigned TOTAL_W = TERM_W + 1;

   // largest term magnitude, 2^60
   localparam logic [PROD_W-1:0] TERM_CAP = {{(PROD_W-61){1'b0}}, 1'b1, 60'd0};

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PROP_GAIN        = 3'd0,
      CSR_INTEG_GAIN       = 3'd1,
      CSR_DERIV_GAIN       = 3'd2,
      CSR_ACCUMULATE_BOUND = 3'd3,
      CSR_SUM_LIMIT        = 3'd4,
      CSR_SLEW_STEP        = 3'd5,
      CSR_DRIVE_LIMIT      = 3'd6
   } csr_index_type;

   // one signed product request, given as sign and magnitudes
   typedef struct packed {
      logic              neg;
      logic [OP_A_W-1:0] a_mag;
      logic [OP_B_W-1:0] b_mag;
   } term_op_type;

endpackage

### rtl/core/pidsl_term.sv
// pidsl_term: two stage product unit, (a * b) >> FRAC_BITS toward zero,
// magnitude capped at 2^60, signed result
// depends on pidsl_pkg
`timescale 1ns / 1ps

module pidsl_term (
   input  logic                                  clock,
   input  logic                                  advance,
   input  pidsl_pkg::term_op_type                op,
   output logic signed [pidsl_pkg::TERM_W-1:0]   term
);
   import pidsl_pkg::*;

   logic [SPLIT_W+OP_B_W-1:0]        lo_ff, lo_in;
   logic [OP_A_W-SPLIT_W+OP_B_W-1:0] hi_ff, hi_in;
   logic                             neg_ff;
   logic [PROD_W-1:0]                prod;
   logic [PROD_W-1:0]                shifted;
   logic [TERM_W-1:0]                mag;
   logic signed [TERM_W-1:0]         term_ff, term_in;

   // partial products on the low and high slices of a
   assign lo_in = op.a_mag[SPLIT_W-1:0] * op.b_mag;
   assign hi_in = op.a_mag[OP_A_W-1:SPLIT_W] * op.b_mag;

   // recombine, scale, cap and apply sign
   assign prod    = {hi_ff, {SPLIT_W{1'b0}}} + PROD_W'(lo_ff);
   assign shifted = prod >> FRAC_BITS;
   assign mag     = (shifted > TERM_CAP) ? TERM_CAP[TERM_W-1:0] : shifted[TERM_W-1:0];
   assign term_in = neg_ff ? -$signed(mag) : $signed(mag);

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         neg_ff  <= op.neg;
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

### rtl/core/pid_with_slew_and_windup_limit_core.sv
// pid_with_slew_and_windup_limit_core: pipelined fixed point pid controller
// with integral windup limit, slew limit and drive cap
// depends on pidsl_pkg and pidsl_term
// req beats pass the input, operand, term unit, sum and output registers to
// rsp_valid, one beat per cycle unless stalled; the integrator loop closes
// in one stage, the slew loop on the previous drive in the output stage
// req_stall rises only while a finished rsp beat is held by rsp_stall
// reset (synchronous) clears the pipeline, the state and the registers;
// drive_limit comes out of reset at its largest value
`timescale 1ns / 1ps

module pid_with_slew_and_windup_limit_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pidsl_pkg::DATA_W-1:0]    req_error_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pidsl_pkg::DATA_W-1:0]    rsp_drive_value,
   output logic                                   rsp_drive_capped,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  pidsl_pkg::csr_index_type               csr_index,
   input  logic [pidsl_pkg::LIMIT_W-1:0]          csr_wdata
);
   import pidsl_pkg::*;

   localparam int unsigned WIDE_W  = DATA_W + 1;
   localparam int unsigned ACC_W   = SUM_W + 1;
   localparam int unsigned SLEW_W  = DATA_W + 2;
   localparam int unsigned STAGES  = 6;
   localparam logic signed [TOTAL_W-1:0] SAT_HI = TOTAL_W'(64'sh7FFF_FFFF);
   localparam logic signed [TOTAL_W-1:0] SAT_LO = -TOTAL_W'(64'sh8000_0000);

   // configuration registers
   logic [DATA_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [STEP_W-1:0]  accumulate_bound_ff, slew_step_ff, drive_limit_ff;
   logic [LIMIT_W-1:0] sum_limit_ff;

   // pipeline control
   logic [STAGES-1:0] valid_ff, valid_in;
   logic              advance;

   // controller state
   logic signed [DATA_W-1:0] prev_error_ff;
   logic signed [SUM_W-1:0]  error_sum_ff, error_sum_in;
   logic signed [DATA_W-1:0] prev_drive_ff;

   // stage payloads
   logic signed [DATA_W-1:0]  err_ff;
   term_op_type               op_prop_ff, op_prop_in;
   term_op_type               op_integ_ff, op_integ_in;
   term_op_type               op_deriv_ff, op_deriv_in;
   logic signed [TERM_W-1:0]  term_prop, term_integ, term_deriv;
   logic signed [DATA_W-1:0]  sat_ff, sat_in;
   logic                      sat_capped_ff, sat_capped_in;
   logic signed [DATA_W-1:0]  drive_ff, drive_in;
   logic                      capped_ff, capped_in;

   // error stage signals
   logic signed [WIDE_W-1:0] err_wide, err_neg_wide, delta, delta_used, delta_neg_wide;
   logic                     e_neg, e_zero, d_neg, d_zero, p_neg, p_zero;
   logic                     delta_same_sign, sign_change, accumulate;
   logic [DATA_W-1:0]        err_mag;
   logic [WIDE_W-1:0]        delta_mag;
   logic signed [ACC_W-1:0]  sum_acc, sum_clr, limit_pos, limit_neg;
   logic signed [SUM_W-1:0]  sum_neg_wide;
   logic [LIMIT_W-1:0]       sum_mag;
   logic [DATA_W-1:0]        prop_mag, integ_mag, deriv_mag;

   // sum stage signals
   logic signed [TOTAL_W-1:0] total;

   // output stage signals
   logic signed [SLEW_W-1:0] sat_w, prev_w, step_w, up_lim, dn_lim;
   logic signed [SLEW_W-1:0] slew_a, slew_b, lim_w, lim_neg, d_neg_wide;
   logic [SLEW_W-1:0]        d_mag;
   logic                     slew_on, over;

   // handshakes: one global advance, held only by a stalled result
   assign advance   = !(valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff        <= '0;
         integ_gain_ff       <= '0;
         deriv_gain_ff       <= '0;
         accumulate_bound_ff <= '0;
         sum_limit_ff        <= '0;
         slew_step_ff        <= '0;
         drive_limit_ff      <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROP_GAIN:        prop_gain_ff        <= csr_wdata[DATA_W-1:0];
            CSR_INTEG_GAIN:       integ_gain_ff       <= csr_wdata[DATA_W-1:0];
            CSR_DERIV_GAIN:       deriv_gain_ff       <= csr_wdata[DATA_W-1:0];
            CSR_ACCUMULATE_BOUND: accumulate_bound_ff <= csr_wdata[STEP_W-1:0];
            CSR_SUM_LIMIT:        sum_limit_ff        <= csr_wdata;
            CSR_SLEW_STEP:        slew_step_ff        <= csr_wdata[STEP_W-1:0];
            CSR_DRIVE_LIMIT:      drive_limit_ff      <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff <= req_error_value;
      end
   end

   // gain magnitudes
   assign prop_mag  = prop_gain_ff[DATA_W-1]  ? (~prop_gain_ff + DATA_W'(1))  : prop_gain_ff;
   assign integ_mag = integ_gain_ff[DATA_W-1] ? (~integ_gain_ff + DATA_W'(1)) : integ_gain_ff;
   assign deriv_mag = deriv_gain_ff[DATA_W-1] ? (~deriv_gain_ff + DATA_W'(1)) : deriv_gain_ff;

   // error change, zeroed when it moves with the error's own sign
   assign err_wide     = {err_ff[DATA_W-1], err_ff};
   assign err_neg_wide = -err_wide;
   assign delta        = err_wide - {prev_error_ff[DATA_W-1], prev_error_ff};
   assign e_neg        = err_ff[DATA_W-1];
   assign e_zero       = (err_ff == '0);
   assign d_neg        = delta[WIDE_W-1];
   assign d_zero       = (delta == '0);
   assign p_neg        = prev_error_ff[DATA_W-1];
   assign p_zero       = (prev_error_ff == '0);
   assign delta_same_sign = (d_zero && e_zero) || (d_neg && e_neg)
                         || (!d_neg && !d_zero && !e_neg && !e_zero);
   assign delta_used     = delta_same_sign ? '0 : delta;
   assign delta_neg_wide = -delta_used;
   assign delta_mag      = delta_used[WIDE_W-1] ? delta_neg_wide : delta_used;
   assign err_mag        = e_neg ? err_neg_wide[DATA_W-1:0] : err_ff;

   // integrator: gated accumulate, clear on sign change, clamp to the limit
   assign sign_change = !((e_zero && p_zero) || (e_neg && p_neg)
                       || (!e_neg && !e_zero && !p_neg && !p_zero));
   assign accumulate  = err_mag < {1'b0, accumulate_bound_ff};
   assign sum_acc     = {error_sum_ff[SUM_W-1], error_sum_ff}
                      + (accumulate ? ACC_W'(err_ff) : '0);
   assign sum_clr     = sign_change ? '0 : sum_acc;
   assign limit_pos   = $signed({2'b00, sum_limit_ff});
   assign limit_neg   = -limit_pos;

   always_comb begin
      priority if (sum_clr > limit_pos) begin
         error_sum_in = limit_pos[SUM_W-1:0];
      end else if (sum_clr < limit_neg) begin
         error_sum_in = limit_neg[SUM_W-1:0];
      end else begin
         error_sum_in = sum_clr[SUM_W-1:0];
      end
   end

   assign sum_neg_wide = -error_sum_in;
   assign sum_mag      = error_sum_in[SUM_W-1] ? sum_neg_wide[LIMIT_W-1:0]
                                               : error_sum_in[LIMIT_W-1:0];

   // product requests for the three terms
   assign op_prop_in  = '{neg: e_neg ^ prop_gain_ff[DATA_W-1],
                          a_mag: OP_A_W'(err_mag), b_mag: prop_mag};
   assign op_integ_in = '{neg: error_sum_in[SUM_W-1] ^ integ_gain_ff[DATA_W-1],
                          a_mag: sum_mag, b_mag: integ_mag};
   assign op_deriv_in = '{neg: delta_used[WIDE_W-1] ^ deriv_gain_ff[DATA_W-1],
                          a_mag: OP_A_W'(delta_mag), b_mag: deriv_mag};

   // state update and operand register
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (advance && valid_ff[0]) begin
         prev_error_ff <= err_ff;
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_prop_ff  <= op_prop_in;
         op_integ_ff <= op_integ_in;
         op_deriv_ff <= op_deriv_in;
      end
   end

   // term units
   pidsl_term u_term_prop (
      .clock   (clock),
      .advance (advance),
      .op      (op_prop_ff),
      .term    (term_prop)
   );

   pidsl_term u_term_integ (
      .clock   (clock),
      .advance (advance),
      .op      (op_integ_ff),
      .term    (term_integ)
   );

   pidsl_term u_term_deriv (
      .clock   (clock),
      .advance (advance),
      .op      (op_deriv_ff),
      .term    (term_deriv)
   );

   // sum of terms, saturated to the drive range
   assign total = TOTAL_W'(term_prop) + TOTAL_W'(term_integ) + TOTAL_W'(term_deriv);

   always_comb begin
      priority if (total > SAT_HI) begin
         sat_in        = SAT_HI[DATA_W-1:0];
         sat_capped_in = 1'b1;
      end else if (total < SAT_LO) begin
         sat_in        = SAT_LO[DATA_W-1:0];
         sat_capped_in = 1'b1;
      end else begin
         sat_in        = total[DATA_W-1:0];
         sat_capped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sat_ff        <= sat_in;
         sat_capped_ff <= sat_capped_in;
      end
   end

   // slew limit against the previous drive, off when slew_step is zero
   assign sat_w   = SLEW_W'(sat_ff);
   assign prev_w  = SLEW_W'(prev_drive_ff);
   assign step_w  = $signed({3'b000, slew_step_ff});
   assign up_lim  = prev_w + step_w;
   assign dn_lim  = prev_w - step_w;
   assign slew_on = (slew_step_ff != '0);
   assign slew_a  = (slew_on && (sat_w > 0) && (sat_w > up_lim)) ? up_lim : sat_w;
   assign slew_b  = (slew_on && (slew_a < 0) && (slew_a < dn_lim)) ? dn_lim : slew_a;

   // drive cap
   assign d_neg_wide = -slew_b;
   assign d_mag      = slew_b[SLEW_W-1] ? d_neg_wide : slew_b;
   assign lim_w      = $signed({3'b000, drive_limit_ff});
   assign lim_neg    = -lim_w;
   assign over       = d_mag > lim_w;
   assign drive_in   = over ? (slew_b[SLEW_W-1] ? lim_neg[DATA_W-1:0] : lim_w[DATA_W-1:0])
                            : slew_b[DATA_W-1:0];
   assign capped_in  = sat_capped_ff || over;

   // output register and previous drive
   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff  <= drive_in;
         capped_ff <= capped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_drive_ff <= '0;
      end else if (advance && valid_ff[STAGES-2]) begin
         prev_drive_ff <= drive_in;
      end
   end

   assign rsp_valid        = valid_ff[STAGES-1];
   assign rsp_drive_value  = drive_ff;
   assign rsp_drive_capped = capped_ff;

   // a delivered drive never exceeds the drive limit
   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_value <= $signed({1'b0, drive_limit_ff}))
                 && (rsp_drive_value >= -$signed({1'b0, drive_limit_ff})))
      else $error("drive beyond drive limit");

   // the integrator stays inside the sum limit after each update
   a_sum_in_limit: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[0]) |=>
         ($signed({error_sum_ff[SUM_W-1], error_sum_ff}) <= $signed({2'b00, sum_limit_ff}))
         && ($signed({error_sum_ff[SUM_W-1], error_sum_ff})
             >= -$signed({2'b00, sum_limit_ff})))
      else $error("integrator beyond sum limit");

   // a sign change of the error clears the integrator
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[0] && sign_change) |=> (error_sum_ff == '0))
      else $error("integrator not cleared on sign change");

   // the previous drive tracks the last delivered drive
   a_prev_drive: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[STAGES-2]) |=> (prev_drive_ff == rsp_drive_value))
      else $error("previous drive out of step with output");

endmodule
